>>> hdl/hsha_pkg.sv
// Package: HMAC-SHA256 types, constants and round functions.
`default_nettype none
package hsha_pkg;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;

  localparam logic [7:0][31:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } out_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_ITEM = 11'b000_0000_0010,
    S_POST = 11'b000_0000_0100,
    S_PAD  = 11'b000_0000_1000,
    S_LOAD = 11'b000_0001_0000,
    S_RND  = 11'b000_0010_0000,
    S_FIN  = 11'b000_0100_0000,
    S_IDG  = 11'b000_1000_0000,
    S_DRD  = 11'b001_0000_0000,
    S_DBY  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    P_MARK = 3'b001,
    P_ZERO = 3'b010,
    P_LEN  = 3'b100
  } pstg_e;

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> hdl/hsha_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`default_nettype none
interface hsha_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/hmac_sha256_message_authenticator.sv
// Top level: HMAC-SHA256 over a byte stream, block buffer and inner digest in RAM.
//
//  channel | dir | handshake         | payload
//  in_if   | in  | valid/ready       | data_byte, byte_present, last
//  out_if  | out | valid/ready       | digest_word0..3
//  cfg     | in  | cfg_we_i          | cfg_idx_i, cfg_data_i (key words)
//
// A message byte passes through accept, absorb and end check; the byte that fills
// a 64-byte block then adds the buffer RAM load, 64 rounds and the chain
// update. The first item of a message first hashes the inner key block;
// the last item adds padding, the outer key block and the outer hash.
// No clearing pass after reset. The result register frees input while
// a digest waits; a new digest stalls until the previous one is taken.
`default_nettype none
module hmac_sha256_message_authenticator
  import hsha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hsha_stream_if.sink      in_if,
  hsha_stream_if.source    out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);
  state_e state_q, state_d, ret_q, ret_d;
  pstg_e  pstg_q, pstg_d;
  logic [7:0][63:0]  key_q;
  logic [7:0][31:0]  h_q, h_d, v_q, v_d, rv;
  logic [15:0][31:0] w_q, w_d, rw;
  logic [63:0] len_q, len_d, lsnap_q, lsnap_d;
  logic [23:0] acc_q, acc_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [4:0]  cnt_q, cnt_d, bcnt_q, bcnt_d;
  logic        phase_q, phase_d, outer_q, outer_d, out_vld_q, out_vld_d;
  in_t         item_q, item_d;
  out_t        out_q, out_d;

  logic [31:0] buf_mem [16];
  logic [31:0] idg_mem [8];
  logic [31:0] buf_rd_q, idg_rd_q, buf_wdata;
  logic [3:0]  buf_raddr, buf_waddr;
  logic        buf_we, idg_we, ab_en, key_ld;
  logic [7:0]  ab_byte, key_pad;
  logic [5:0]  pos, shamt;

  hsha_round u_round (
    .v_i (v_q),
    .w_i (w_q),
    .k_i (k_const(rnd_q)),
    .v_o (rv),
    .w_o (rw)
  );

  assign pos          = len_q[8:3];
  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = out_vld_q;
  assign out_if.payload = out_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q; pstg_d = pstg_q;
    h_d = h_q; v_d = v_q; w_d = w_q;
    len_d = len_q; lsnap_d = lsnap_q; acc_d = acc_q;
    rnd_d = rnd_q; cnt_d = cnt_q; bcnt_d = bcnt_q;
    phase_d = phase_q; outer_d = outer_q; item_d = item_q; out_d = out_q;
    out_vld_d = out_vld_q & ~out_if.ready;
    ab_en = 1'b0; ab_byte = 8'h00; key_ld = 1'b0; key_pad = IPAD;
    buf_we = 1'b0; buf_waddr = pos[5:2]; buf_wdata = {acc_q, ab_byte};
    buf_raddr = cnt_q[3:0]; idg_we = 1'b0;
    shamt = {3'(3'd7 - cnt_q[2:0]), 3'b000};

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          item_d  = in_if.payload;
          outer_d = 1'b0;
          if (!phase_q) begin
            key_ld  = 1'b1;
            key_pad = IPAD;
            phase_d = 1'b1;
            ret_d   = S_ITEM;
          end else begin
            state_d = S_ITEM;
          end
        end
      end
      S_ITEM: begin
        ab_en   = item_q.byte_present;
        ab_byte = item_q.data_byte;
        ret_d   = S_POST;
        state_d = S_POST;
      end
      S_POST: begin
        if (item_q.last) begin
          lsnap_d = len_q;
          pstg_d  = P_MARK;
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        ab_en = 1'b1;
        ret_d = S_PAD;
        case (pstg_q)
          P_MARK: begin
            ab_byte = 8'h80;
            cnt_d   = '0;
            pstg_d  = (pos == 6'd55) ? P_LEN : P_ZERO;
          end
          P_ZERO: begin
            ab_byte = 8'h00;
            cnt_d   = '0;
            if (pos == 6'd55) pstg_d = P_LEN;
          end
          P_LEN: begin
            ab_byte = lsnap_q[shamt +: 8];
            cnt_d   = cnt_q + 5'd1;
            if (cnt_q[2:0] == 3'd7) ret_d = outer_q ? S_OUT : S_IDG;
          end
          default: pstg_d = P_MARK;
        endcase
      end
      S_LOAD: begin
        if (cnt_q != 5'd0) w_d = {buf_rd_q, w_q[15:1]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          v_d     = h_q;
          rnd_d   = '0;
          state_d = S_RND;
        end
      end
      S_RND: begin
        v_d   = rv;
        w_d   = rw;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = S_FIN;
      end
      S_FIN: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        cnt_d   = '0;
        state_d = ret_q;
      end
      S_IDG: begin
        idg_we = 1'b1;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q[2:0] == 3'd7) begin
          key_ld  = 1'b1;
          key_pad = OPAD;
          outer_d = 1'b1;
          bcnt_d  = '0;
          ret_d   = S_DRD;
        end
      end
      S_DRD: state_d = S_DBY;
      S_DBY: begin
        ab_en   = 1'b1;
        ab_byte = idg_rd_q[{~bcnt_q[1:0], 3'b000} +: 8];
        bcnt_d  = bcnt_q + 5'd1;
        if (bcnt_q[1:0] == 2'd3) state_d = (bcnt_q == 5'd31) ? S_POST : S_DRD;
      end
      S_OUT: begin
        if (!out_vld_q || out_if.ready) begin
          out_d.digest_word0 = {h_q[0], h_q[1]};
          out_d.digest_word1 = {h_q[2], h_q[3]};
          out_d.digest_word2 = {h_q[4], h_q[5]};
          out_d.digest_word3 = {h_q[6], h_q[7]};
          out_vld_d = 1'b1;
          h_d       = IV;
          len_d     = '0;
          phase_d   = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (ab_en) begin
      acc_d     = {acc_q[15:0], ab_byte};
      buf_wdata = {acc_q, ab_byte};
      buf_we    = (pos[1:0] == 2'd3);
      len_d     = len_q + 64'd8;
      if (pos == 6'd63) begin
        state_d = S_LOAD;
        cnt_d   = '0;
      end
    end

    if (key_ld) begin
      h_d = IV;
      v_d = IV;
      for (int i = 0; i < 16; i++) begin
        w_d[i] = (i[0] ? key_q[i>>1][31:0] : key_q[i>>1][63:32]) ^ {4{key_pad}};
      end
      len_d   = 64'd512;
      rnd_d   = '0;
      state_d = S_RND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      pstg_q    <= P_MARK;
      key_q     <= '0;
      h_q       <= IV;
      len_q     <= '0;
      rnd_q     <= '0;
      cnt_q     <= '0;
      bcnt_q    <= '0;
      phase_q   <= 1'b0;
      outer_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      pstg_q    <= pstg_d;
      h_q       <= h_d;
      len_q     <= len_d;
      rnd_q     <= rnd_d;
      cnt_q     <= cnt_d;
      bcnt_q    <= bcnt_d;
      phase_q   <= phase_d;
      outer_q   <= outer_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    w_q     <= w_d;
    acc_q   <= acc_d;
    lsnap_q <= lsnap_d;
    item_q  <= item_d;
    out_q   <= out_d;
  end

  // block buffer RAM, one word per four bytes
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_rd_q <= buf_mem[buf_raddr];
  end

  // inner digest RAM
  always_ff @(posedge clk_i) begin
    if (idg_we) idg_mem[cnt_q[2:0]] <= h_q[cnt_q[2:0]];
    idg_rd_q <= idg_mem[bcnt_q[4:2]];
  end

  a_len_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q[2:0] == 3'b000) else $error("bit length not byte aligned");

  a_load_to_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && cnt_q == 5'd16) |=> state_q == S_RND)
    else $error("block load did not start rounds");

  a_dig_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DBY |-> pos != 6'd63) else $error("inner digest crossed a block");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_vld_q) |=> (out_vld_q && state_q == S_IDLE))
    else $error("digest not delivered");

  a_rnd_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RND && rnd_q == 6'd63) |=> state_q == S_FIN)
    else $error("round count overrun");

endmodule
`default_nettype wire

>>> hdl/hsha_round.sv
// Module: one SHA-256 compression round and message schedule step.
`default_nettype none
module hsha_round
  import hsha_pkg::*;
(
  input  wire logic [7:0][31:0]  v_i,
  input  wire logic [15:0][31:0] w_i,
  input  wire logic [31:0]       k_i,
  output logic      [7:0][31:0]  v_o,
  output logic      [15:0][31:0] w_o
);
  logic [31:0] ch, maj, t1, t2;

  always_comb begin
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1  = v_i[7] + big_s1(v_i[4]) + ch + k_i + w_i[0];
    t2  = big_s0(v_i[0]) + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
    // window slides down; slot 15 gets W[t+16]
    for (int i = 0; i < 15; i++) begin
      w_o[i] = w_i[i+1];
    end
    w_o[15] = sml_s1(w_i[14]) + w_i[9] + sml_s0(w_i[1]) + w_i[0];
  end
endmodule
`default_nettype wire
